// ===== rtl/hwms_pkg.sv =====
// hwms_pkg: shared types and constants for the hourglass window max-sum block
// no dependencies; imported by every module under rtl

package hwms_pkg;

    // configuration register geometry
    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1
    } cfg_reg_e;

    localparam logic [CFG_BITS-1:0] GRID_DIM_RESET = 11'd6;
    localparam logic [CFG_BITS-1:0] GRID_DIM_MIN   = 11'd3;

    // first column / row at which a full 3x3 window exists
    localparam int WINDOW_FIRST_POS = 2;

    // per-sample control that travels down the pipeline
    typedef struct packed {
        logic win_ok;    // window is complete at this position
        logic grid_end;  // last sample of the grid
    } hwms_tag_t;

endpackage

// ===== rtl/hwms_scan.sv =====
// hwms_scan: raster position counters with size clamping and saturation
// depends on hwms_pkg

module hwms_scan
    import hwms_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COL_BITS   = $clog2(MAX_WIDTH),
    parameter int ROW_BITS   = $clog2(MAX_HEIGHT)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [CFG_BITS-1:0] grid_width,
    input  logic [CFG_BITS-1:0] grid_height,
    output logic [COL_BITS-1:0] col,
    output hwms_tag_t           tag
);

    logic [COL_BITS-1:0] col_reg;
    logic [COL_BITS-1:0] col_next;
    logic [ROW_BITS-1:0] row_reg;
    logic [ROW_BITS-1:0] row_next;
    logic [CFG_BITS-1:0] w_eff;
    logic [CFG_BITS-1:0] h_eff;
    logic [COL_BITS-1:0] col_sat;
    logic [ROW_BITS-1:0] row_sat;
    logic                col_end;
    logic                row_end;

    function automatic logic [CFG_BITS-1:0] clamp_dim(
        input logic [CFG_BITS-1:0] v,
        input int unsigned         hi
    );
        logic [CFG_BITS-1:0] r;
        if (v < GRID_DIM_MIN)
            r = GRID_DIM_MIN;
        else if (32'(v) > hi)
            r = CFG_BITS'(hi);
        else
            r = v;
        return r;
    endfunction

    always_comb
    begin
        w_eff   = clamp_dim(grid_width, MAX_WIDTH);
        h_eff   = clamp_dim(grid_height, MAX_HEIGHT);
        col_sat = (32'(col_reg) >= 32'(w_eff)) ? COL_BITS'(w_eff - 11'd1) : col_reg;
        row_sat = (32'(row_reg) >= 32'(h_eff)) ? ROW_BITS'(h_eff - 11'd1) : row_reg;
        col_end = (32'(col_sat) == 32'(w_eff) - 32'd1);
        row_end = (32'(row_sat) == 32'(h_eff) - 32'd1);
        tag.win_ok   = (32'(col_sat) >= 32'(WINDOW_FIRST_POS))
                    && (32'(row_sat) >= 32'(WINDOW_FIRST_POS));
        tag.grid_end = col_end && row_end;
        col = col_sat;

        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_sat + ROW_BITS'(1);
        end
        else
        begin
            col_next = col_sat + COL_BITS'(1);
            row_next = row_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/hwms_line_store.sv =====
// hwms_line_store: the two previous rows, one entry per column, registered read
// depends on hwms_pkg

module hwms_line_store
    import hwms_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = $clog2(DEPTH),
    parameter int DATA_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [ADDR_BITS-1:0]        rd_addr,
    input  logic                        wr_en,
    input  logic [ADDR_BITS-1:0]        wr_addr,
    input  logic signed [DATA_BITS-1:0] wr_sample,
    output logic signed [DATA_BITS-1:0] rd_upper,
    output logic signed [DATA_BITS-1:0] rd_lower
);

    logic signed [DATA_BITS-1:0] upper_mem [DEPTH];
    logic signed [DATA_BITS-1:0] lower_mem [DEPTH];
    logic signed [DATA_BITS-1:0] rd_upper_reg;
    logic signed [DATA_BITS-1:0] rd_lower_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_upper_reg <= upper_mem[rd_addr];
            rd_lower_reg <= lower_mem[rd_addr];
        end
    end

    // rows move up by one: the row just read as lower becomes upper
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr] <= rd_lower_reg;
            lower_mem[wr_addr] <= wr_sample;
        end
    end

    assign rd_upper = rd_upper_reg;
    assign rd_lower = rd_lower_reg;

endmodule

// ===== rtl/hwms_window.sv =====
// hwms_window: 3x3 sliding window and registered hourglass sum
// depends on hwms_pkg

module hwms_window
    import hwms_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = SAMPLE_BITS + 3
)
(
    input  logic                          clk,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] col_upper,
    input  logic signed [SAMPLE_BITS-1:0] col_lower,
    input  logic signed [SAMPLE_BITS-1:0] col_sample,
    output logic signed [SUM_BITS-1:0]    sum
);

    // win_reg[row][column], row 0 oldest line, column 2 newest
    logic signed [SAMPLE_BITS-1:0] win_reg [3][3];
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic signed [SUM_BITS-1:0]    sum_next;

    // sum over the window after the shift
    always_comb
    begin
        sum_next = SUM_BITS'(win_reg[0][1]) + SUM_BITS'(win_reg[0][2])
                 + SUM_BITS'(col_upper)
                 + SUM_BITS'(win_reg[1][2])
                 + SUM_BITS'(win_reg[2][1]) + SUM_BITS'(win_reg[2][2])
                 + SUM_BITS'(col_sample);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= col_upper;
            win_reg[1][2] <= col_lower;
            win_reg[2][2] <= col_sample;
            sum_reg       <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== rtl/hwms_max_out.sv =====
// hwms_max_out: running maximum of window sums and the result register
// depends on hwms_pkg

module hwms_max_out
    import hwms_pkg::*;
#(
    parameter int SUM_BITS = 19
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       sum_valid,
    input  hwms_tag_t                  sum_tag,
    input  logic signed [SUM_BITS-1:0] sum,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [SUM_BITS-1:0] max_sum,
    output logic                       stall
);

    localparam logic signed [SUM_BITS-1:0] MOST_NEG = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic signed [SUM_BITS-1:0] best_reg;
    logic signed [SUM_BITS-1:0] best_cand;
    logic signed [SUM_BITS-1:0] max_sum_reg;
    logic                       out_valid_reg;
    logic                       emit;

    always_comb
    begin
        best_cand = (sum_tag.win_ok && (sum > best_reg)) ? sum : best_reg;
        emit      = en && sum_valid && sum_tag.grid_end;
        // a finished grid cannot leave while the previous result is still held
        stall     = sum_valid && sum_tag.grid_end && out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= MOST_NEG;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en && sum_valid)
                best_reg <= sum_tag.grid_end ? MOST_NEG : best_cand;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            max_sum_reg <= best_cand;
    end

    assign out_valid = out_valid_reg;
    assign max_sum   = max_sum_reg;

endmodule

// ===== rtl/hourglass_window_max_sum_top.sv =====
// hourglass_window_max_sum_top: top level of the hourglass window max-sum block
// depends on hwms_pkg, hwms_scan, hwms_line_store, hwms_window, hwms_max_out

// Takes a raster grid of signed samples, one sample per input transaction,
// and returns one transaction per grid carrying the largest seven-cell
// hourglass sum (top three, centre, bottom three of every 3x3 window). The
// block accepts one sample every clock cycle while not held off; after a grid's
// last sample, the result reaches the output register via stages a and b. The
// only thing that holds off input is a finished grid result meeting an
// output register that still holds the previous grid's result. The line
// stores are one memory per row with one read and one write each cycle; their
// contents need no clearing after reset. Grid width and height are taken from
// configuration registers (index 0 width, index 1 height, reset 6 each, clamped to
// 3..MAX_WIDTH / 3..MAX_HEIGHT); the user must write them only while idle, unenforced.

module hourglass_window_max_sum_top
    import hwms_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [CFG_BITS-1:0]             cfg_data,
    // sample channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_BITS+2:0]   max_sum
);

    localparam int SUM_BITS = SAMPLE_BITS + 3;
    localparam int COL_BITS = $clog2(MAX_WIDTH);

    // configuration registers
    logic [CFG_BITS-1:0] grid_width_reg;
    logic [CFG_BITS-1:0] grid_height_reg;

    // pipeline control
    logic      accept;
    logic      en;
    logic      stall;
    logic      a_valid_reg;
    logic      b_valid_reg;
    hwms_tag_t scan_tag;
    hwms_tag_t a_tag_reg;
    hwms_tag_t b_tag_reg;

    // pipeline payload
    logic [COL_BITS-1:0]           scan_col;
    logic [COL_BITS-1:0]           a_col_reg;
    logic signed [SAMPLE_BITS-1:0] a_sample_reg;
    logic signed [SAMPLE_BITS-1:0] rd_upper;
    logic signed [SAMPLE_BITS-1:0] rd_lower;
    logic signed [SUM_BITS-1:0]    win_sum;

    // the whole pipeline moves together; it only holds when a grid result is blocked
    assign en       = !stall;
    assign in_ready = en;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_DIM_RESET;
            grid_height_reg <= GRID_DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // raster position of the incoming sample
    hwms_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .col         (scan_col),
        .tag         (scan_tag)
    );

    // stage a: line store read in flight, sample and position held
    // stage b: window shifted, hourglass sum registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sample_reg <= sample;
            a_col_reg    <= scan_col;
            a_tag_reg    <= scan_tag;
        end
        if (en && a_valid_reg)
            b_tag_reg <= a_tag_reg;
    end

    // consecutive samples never share a column, so read and write never collide
    hwms_line_store #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (SAMPLE_BITS)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr   (scan_col),
        .wr_en     (en && a_valid_reg),
        .wr_addr   (a_col_reg),
        .wr_sample (a_sample_reg),
        .rd_upper  (rd_upper),
        .rd_lower  (rd_lower)
    );

    hwms_window #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_window (
        .clk        (clk),
        .load       (en && a_valid_reg),
        .col_upper  (rd_upper),
        .col_lower  (rd_lower),
        .col_sample (a_sample_reg),
        .sum        (win_sum)
    );

    // running maximum and result register
    hwms_max_out #(
        .SUM_BITS (SUM_BITS)
    ) u_max_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .sum_valid (b_valid_reg),
        .sum_tag   (b_tag_reg),
        .sum       (win_sum),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .max_sum   (max_sum),
        .stall     (stall)
    );

endmodule

// ===== rtl/hwms_checker.sv =====
// hwms_checker: port-level assertions for the hourglass window max-sum block
// depends on hwms_pkg and hourglass_window_max_sum_top (bound below)

module hwms_checker
    import hwms_pkg::*;
#(
    parameter int SUM_BITS = 19
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SUM_BITS-1:0] max_sum
);

    // a held result keeps its value until the transaction completes
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(max_sum))
        else $error("result changed while stalled");

    // input is only held off by a result that cannot leave
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a blocked result");

    // a new result must be preceded by the acceptance of the grid's last sample
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 3))
        else $error("result without a matching sample three cycles earlier");

endmodule

bind hourglass_window_max_sum_top hwms_checker #(
    .SUM_BITS (SAMPLE_BITS + 3)
) u_hwms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .max_sum   (max_sum)
);
